### hw/rtl/clst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clst_pkg;

   localparam int CNT_OUT_W = 11;

   localparam logic [3:0] OP_QUERY        = 4'd0;
   localparam logic [3:0] OP_CLEAR        = 4'd1;
   localparam logic [3:0] OP_FRONT        = 4'd2;
   localparam logic [3:0] OP_BACK         = 4'd3;
   localparam logic [3:0] OP_NEXT         = 4'd4;
   localparam logic [3:0] OP_PREV         = 4'd5;
   localparam logic [3:0] OP_INS_AFTER    = 4'd6;
   localparam logic [3:0] OP_INS_BEFORE   = 4'd7;
   localparam logic [3:0] OP_SET_AFTER    = 4'd8;
   localparam logic [3:0] OP_SET_BEFORE   = 4'd9;
   localparam logic [3:0] OP_ERASE_AFTER  = 4'd10;
   localparam logic [3:0] OP_ERASE_BEFORE = 4'd11;
   localparam logic [3:0] OP_FIND_NEXT    = 4'd12;
   localparam logic [3:0] OP_FIND_PREV    = 4'd13;
   localparam logic [3:0] OP_DEDUPE       = 4'd14;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_RANGE     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [3:0]         op;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic signed [31:0]   passed_value;
      logic [CNT_OUT_W-1:0] found_position;
      logic [CNT_OUT_W-1:0] length;
      logic [CNT_OUT_W-1:0] cursor;
      logic signed [31:0]   front_value;
      logic signed [31:0]   back_value;
      logic signed [31:0]   next_value;
      logic signed [31:0]   prev_value;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/clst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module clst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/cursor_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none

// A command without a walk runs the snapshot reads, then strobes its result.
// next/prev first carry one element across the gap; front, back and find carry
// one per element passed. dedupe reads each element and compares it against the
// kept values, then copies each kept value back to rebuild. One command at a time:
// busy falls as the strobe rises, so the next item enters at its end.
// Reset (synchronous, active high) empties the list; the store itself is not cleared.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.

module cursor_list_engine_core #(
   parameter int CAPACITY   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire clst_pkg::req_type req_item,
   output logic                   busy,
   output logic                   rsp_valid,
   output clst_pkg::rsp_type      rsp_item
);

   import clst_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = DATA_WIDTH;
   localparam logic [CW:0]   CAP_W  = (CW + 1)'(CAPACITY);
   localparam logic [CW-1:0] ONE_C  = CW'(1);
   localparam logic [CW:0]   ONE_W  = (CW + 1)'(1);
   localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

   // Walk, snapshot and dedupe sequencer
   typedef enum logic [3:0] {
      S_IDLE, S_MOVE_RD, S_MOVE_WR, S_SNAP,
      S_D_RD, S_D_GET, S_D_SCAN, S_D_CMP, S_C_RD, S_C_WR
   } state_type;

   state_type state_ff, state_in;
   logic [3:0]           op_ff, op_in;
   logic [DW-1:0]        x_ff, x_in;
   logic                 fwd_ff, fwd_in;
   logic [CW-1:0]        b_ff, b_in, a_ff, a_in;
   logic [1:0]           status_ff, status_in;
   logic signed [DW-1:0] passed_ff, passed_in;
   logic [CW-1:0]        found_ff, found_in;
   logic [2:0]           snap_ff, snap_in;
   logic signed [DW-1:0] front_ff, front_in, back_ff, back_in, nxt_ff, nxt_in;
   logic [CW-1:0]        i_ff, i_in, kept_ff, kept_in, k_ff, k_in, newb_ff, newb_in;
   logic [DW-1:0]        v_ff, v_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // Element store and dedupe scratch ports
   logic          mem_we, scr_we;
   logic [AW-1:0] mem_wa, mem_ra, scr_wa, scr_ra;
   logic [DW-1:0] mem_wd, mem_rd, scr_wd, scr_rd;

   // Gap buffer addresses, one bit wider so the ends do not wrap
   logic [CW:0] b_w, a_w, len_w;
   logic [AW-1:0] ad_after, ad_after_m1, ad_prev, ad_b;
   logic [CW:0] t_after, t_after_m1, t_prev, t_elem, t_copy;
   logic        hit;

   clst_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .we      (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   clst_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_scratch (
      .clock   (clock),
      .we      (scr_we),
      .wr_addr (scr_wa),
      .wr_data (scr_wd),
      .rd_addr (scr_ra),
      .rd_data (scr_rd)
   );

   always_comb begin
      b_w         = {1'b0, b_ff};
      a_w         = {1'b0, a_ff};
      len_w       = b_w + a_w;
      t_after     = CAP_W - a_w;
      t_after_m1  = CAP_W - a_w - ONE_W;
      t_prev      = b_w - ONE_W;
      // Elements ahead of the cursor sit at the bottom, the rest at the top
      t_elem      = (i_ff < b_ff) ? {1'b0, i_ff} : {1'b0, i_ff} + CAP_W - len_w;
      t_copy      = (k_ff < newb_ff) ? {1'b0, k_ff} : CAP_W - {1'b0, kept_ff} + {1'b0, k_ff};
      ad_after    = t_after[AW-1:0];
      ad_after_m1 = t_after_m1[AW-1:0];
      ad_prev     = t_prev[AW-1:0];
      ad_b        = b_w[AW-1:0];
      hit         = (mem_rd == x_ff);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      fwd_in       = fwd_ff;
      b_in         = b_ff;
      a_in         = a_ff;
      status_in    = status_ff;
      passed_in    = passed_ff;
      found_in     = found_ff;
      snap_in      = snap_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      nxt_in       = nxt_ff;
      i_in         = i_ff;
      kept_in      = kept_ff;
      k_in         = k_ff;
      newb_in      = newb_ff;
      v_in         = v_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wa       = ad_b;
      mem_wd       = x_ff;
      mem_ra       = ad_after;
      scr_we       = 1'b0;
      scr_wa       = kept_ff[AW-1:0];
      scr_wd       = v_ff;
      scr_ra       = k_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_item.op;
               x_in      = DW'(req_item.operand);
               status_in = ST_OK;
               passed_in = '0;
               found_in  = '0;
               snap_in   = '0;
               state_in  = S_SNAP;
               mem_wd    = DW'(req_item.operand);
               unique case (req_item.op)
                  OP_CLEAR: begin
                     b_in = '0;
                     a_in = '0;
                  end
                  OP_FRONT: begin
                     fwd_in = 1'b0;
                     if (b_ff != '0) state_in = S_MOVE_RD;
                  end
                  OP_BACK: begin
                     fwd_in = 1'b1;
                     if (a_ff != '0) state_in = S_MOVE_RD;
                  end
                  OP_NEXT, OP_FIND_NEXT: begin
                     fwd_in = 1'b1;
                     if (a_ff != '0) state_in = S_MOVE_RD;
                     else status_in = (req_item.op == OP_NEXT) ? ST_RANGE : ST_NOT_FOUND;
                  end
                  OP_PREV, OP_FIND_PREV: begin
                     fwd_in = 1'b0;
                     if (b_ff != '0) state_in = S_MOVE_RD;
                     else status_in = (req_item.op == OP_PREV) ? ST_RANGE : ST_NOT_FOUND;
                  end
                  OP_INS_AFTER: begin
                     if (len_w >= CAP_W) status_in = ST_FULL;
                     else begin
                        mem_we = 1'b1;
                        mem_wa = ad_after_m1;
                        a_in   = a_ff + ONE_C;
                     end
                  end
                  OP_INS_BEFORE: begin
                     if (len_w >= CAP_W) status_in = ST_FULL;
                     else begin
                        mem_we = 1'b1;
                        mem_wa = ad_b;
                        b_in   = b_ff + ONE_C;
                     end
                  end
                  OP_SET_AFTER: begin
                     if (a_ff == '0) status_in = ST_RANGE;
                     else begin
                        mem_we = 1'b1;
                        mem_wa = ad_after;
                     end
                  end
                  OP_SET_BEFORE: begin
                     if (b_ff == '0) status_in = ST_RANGE;
                     else begin
                        mem_we = 1'b1;
                        mem_wa = ad_prev;
                     end
                  end
                  OP_ERASE_AFTER: begin
                     if (a_ff == '0) status_in = ST_RANGE;
                     else a_in = a_ff - ONE_C;
                  end
                  OP_ERASE_BEFORE: begin
                     if (b_ff == '0) status_in = ST_RANGE;
                     else b_in = b_ff - ONE_C;
                  end
                  OP_DEDUPE: begin
                     i_in     = '0;
                     kept_in  = '0;
                     newb_in  = '0;
                     state_in = S_D_RD;
                  end
                  default: ;
               endcase
            end
         end

         S_MOVE_RD: begin
            mem_ra   = fwd_ff ? ad_after : ad_prev;
            state_in = S_MOVE_WR;
         end

         S_MOVE_WR: begin
            // Carry one element across the gap
            mem_we   = 1'b1;
            mem_wa   = fwd_ff ? ad_b : ad_after_m1;
            mem_wd   = mem_rd;
            state_in = S_SNAP;
            if (fwd_ff) begin
               b_in = b_ff + ONE_C;
               a_in = a_ff - ONE_C;
            end else begin
               b_in = b_ff - ONE_C;
               a_in = a_ff + ONE_C;
            end
            case (op_ff)
               OP_NEXT, OP_PREV: passed_in = mem_rd;
               OP_FIND_NEXT: begin
                  if (hit) found_in = b_ff + ONE_C;
                  else if (a_ff == ONE_C) status_in = ST_NOT_FOUND;
                  else state_in = S_MOVE_RD;
               end
               OP_FIND_PREV: begin
                  if (hit) found_in = b_ff - ONE_C;
                  else if (b_ff == ONE_C) status_in = ST_NOT_FOUND;
                  else state_in = S_MOVE_RD;
               end
               OP_FRONT: if (b_ff != ONE_C) state_in = S_MOVE_RD;
               OP_BACK:  if (a_ff != ONE_C) state_in = S_MOVE_RD;
               default: ;
            endcase
         end

         S_SNAP: begin
            // Issue front, back, next, prev reads; capture each in the next cycle
            case (snap_ff)
               3'd0:    mem_ra = (b_ff != '0) ? '0 : ad_after;
               3'd1:    mem_ra = (a_ff != '0) ? LAST_A : ad_prev;
               3'd2:    mem_ra = ad_after;
               default: mem_ra = ad_prev;
            endcase
            case (snap_ff)
               3'd1:    front_in = mem_rd;
               3'd2:    back_in  = mem_rd;
               3'd3:    nxt_in   = mem_rd;
               default: ;
            endcase
            snap_in = snap_ff + 3'd1;
            if (snap_ff == 3'd4) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = status_ff;
               rsp_in.passed_value   = 32'(passed_ff);
               rsp_in.found_position = CNT_OUT_W'(found_ff);
               rsp_in.length         = CNT_OUT_W'(len_w);
               rsp_in.cursor         = CNT_OUT_W'(b_ff);
               rsp_in.front_value    = (len_w != '0) ? 32'(front_ff) : '0;
               rsp_in.back_value     = (len_w != '0) ? 32'(back_ff) : '0;
               rsp_in.next_value     = (a_ff != '0) ? 32'(nxt_ff) : '0;
               rsp_in.prev_value     = (b_ff != '0) ? 32'(signed'(mem_rd)) : '0;
               state_in              = S_IDLE;
            end
         end

         S_D_RD: begin
            mem_ra = t_elem[AW-1:0];
            if ({1'b0, i_ff} == len_w) begin
               k_in = '0;
               if (kept_ff == '0) begin
                  b_in     = '0;
                  a_in     = '0;
                  state_in = S_SNAP;
               end else begin
                  state_in = S_C_RD;
               end
            end else begin
               state_in = S_D_GET;
            end
         end

         S_D_GET: begin
            v_in     = mem_rd;
            k_in     = '0;
            state_in = S_D_SCAN;
         end

         S_D_SCAN: begin
            if (k_ff == kept_ff) begin
               // New value: keep it
               scr_we  = 1'b1;
               kept_in = kept_ff + ONE_C;
               if (i_ff < b_ff) newb_in = newb_ff + ONE_C;
               i_in     = i_ff + ONE_C;
               state_in = S_D_RD;
            end else begin
               state_in = S_D_CMP;
            end
         end

         S_D_CMP: begin
            if (scr_rd == v_ff) begin
               i_in     = i_ff + ONE_C;
               state_in = S_D_RD;
            end else begin
               k_in     = k_ff + ONE_C;
               state_in = S_D_SCAN;
            end
         end

         S_C_RD: begin
            state_in = S_C_WR;
         end

         S_C_WR: begin
            // Rebuild the gap buffer around the adjusted cursor
            mem_we = 1'b1;
            mem_wa = t_copy[AW-1:0];
            mem_wd = scr_rd;
            k_in   = k_ff + ONE_C;
            if (k_ff + ONE_C == kept_ff) begin
               b_in     = newb_ff;
               a_in     = kept_ff - newb_ff;
               state_in = S_SNAP;
            end else begin
               state_in = S_C_RD;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         b_ff         <= '0;
         a_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b_ff         <= b_in;
         a_ff         <= a_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      x_ff      <= x_in;
      fwd_ff    <= fwd_in;
      status_ff <= status_in;
      passed_ff <= passed_in;
      found_ff  <= found_in;
      snap_ff   <= snap_in;
      front_ff  <= front_in;
      back_ff   <= back_in;
      nxt_ff    <= nxt_in;
      i_ff      <= i_in;
      kept_ff   <= kept_in;
      k_ff      <= k_in;
      newb_ff   <= newb_in;
      v_ff      <= v_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/clst_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module clst_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire clst_pkg::req_type req_item,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire clst_pkg::rsp_type rsp_item
);

   import clst_pkg::*;

   // An accepted item always occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");

   // Finishing an item coincides with its strobe
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("busy dropped without a result");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe lasted two cycles");

   a_range_no_find: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status == ST_RANGE || rsp_item.status == ST_FULL)
      |-> rsp_item.found_position == '0) else $error("rejected item reported a find");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.length == '0 && rsp_item.cursor == '0
      |-> rsp_item.front_value == '0 && rsp_item.back_value == '0)
      else $error("empty list reported values");

endmodule

bind cursor_list_engine_core clst_checker u_clst_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .req_item  (req_item),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import clst_pkg::*;

   localparam int          LIST_CAP   = 1024;
   localparam logic [3:0]  OP_SPARE   = 4'd15;  // unused code, behaves as query
   localparam int          STALL_MAX  = 200000;
   localparam int          MAX_REPORT = 10;

   typedef struct {
      req_type cmd;
      bit      drain;   // hold this item until every result is back
      bit      steady;  // present without random idling
   } cmd_slot_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   cmd_slot_type cmd_queue[$];  // commands waiting to be sent
   rsp_type   planned_rsp[$];   // results worked out, command not yet sent
   rsp_type   awaited_rsp[$];   // results of sent commands, oldest first
   int        mismatch_count = 0;
   int        quiet_cycles = 0;
   bit        gen_done = 1'b0;

   // shadow list, kept in plain list order with the cursor as an index
   logic [31:0] shadow_elem[LIST_CAP];
   int          shadow_len = 0;
   int          shadow_cur = 0;
   logic [31:0] value_pool[8];

   cursor_list_engine_core uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   always #4 clock = ~clock;

   // Apply one command to the shadow list and return the result it should produce.
   function automatic rsp_type apply_list_cmd(req_type c);
      rsp_type     r;
      logic [31:0] x;
      logic [31:0] kept[$];
      int          new_cur;
      bit          hit;
      bit          dup;
      r = '0;
      x = c.operand;
      hit = 1'b0;
      new_cur = 0;
      case (c.op)
         OP_CLEAR: begin
            shadow_len = 0;
            shadow_cur = 0;
         end
         OP_FRONT: shadow_cur = 0;
         OP_BACK:  shadow_cur = shadow_len;
         OP_NEXT: begin
            if (shadow_cur == shadow_len) r.status = ST_RANGE;
            else begin
               r.passed_value = shadow_elem[shadow_cur];
               shadow_cur++;
            end
         end
         OP_PREV: begin
            if (shadow_cur == 0) r.status = ST_RANGE;
            else begin
               shadow_cur--;
               r.passed_value = shadow_elem[shadow_cur];
            end
         end
         OP_INS_AFTER, OP_INS_BEFORE: begin
            if (shadow_len >= LIST_CAP) r.status = ST_FULL;
            else begin
               for (int i = shadow_len; i > shadow_cur; i--) shadow_elem[i] = shadow_elem[i-1];
               shadow_elem[shadow_cur] = x;
               shadow_len++;
               if (c.op == OP_INS_BEFORE) shadow_cur++;
            end
         end
         OP_SET_AFTER: begin
            if (shadow_cur == shadow_len) r.status = ST_RANGE;
            else shadow_elem[shadow_cur] = x;
         end
         OP_SET_BEFORE: begin
            if (shadow_cur == 0) r.status = ST_RANGE;
            else shadow_elem[shadow_cur-1] = x;
         end
         OP_ERASE_AFTER, OP_ERASE_BEFORE: begin
            if (c.op == OP_ERASE_AFTER ? shadow_cur == shadow_len : shadow_cur == 0)
               r.status = ST_RANGE;
            else begin
               if (c.op == OP_ERASE_BEFORE) shadow_cur--;
               for (int i = shadow_cur; i < shadow_len - 1; i++) shadow_elem[i] = shadow_elem[i+1];
               shadow_len--;
            end
         end
         OP_FIND_NEXT: begin
            while (shadow_cur < shadow_len && !hit) begin
               hit = (shadow_elem[shadow_cur] == x);
               shadow_cur++;
            end
            if (hit) r.found_position = CNT_OUT_W'(shadow_cur);
            else r.status = ST_NOT_FOUND;
         end
         OP_FIND_PREV: begin
            while (shadow_cur > 0 && !hit) begin
               shadow_cur--;
               hit = (shadow_elem[shadow_cur] == x);
            end
            if (hit) r.found_position = CNT_OUT_W'(shadow_cur);
            else r.status = ST_NOT_FOUND;
         end
         OP_DEDUPE: begin
            for (int i = 0; i < shadow_len; i++) begin
               dup = 1'b0;
               foreach (kept[k]) if (kept[k] == shadow_elem[i]) dup = 1'b1;
               if (!dup) begin
                  kept.push_back(shadow_elem[i]);
                  if (i < shadow_cur) new_cur++;
               end
            end
            foreach (kept[k]) shadow_elem[k] = kept[k];
            shadow_len = kept.size();
            shadow_cur = new_cur;
         end
         default: ;  // query and the spare code change nothing
      endcase
      r.length = CNT_OUT_W'(shadow_len);
      r.cursor = CNT_OUT_W'(shadow_cur);
      if (shadow_len > 0) begin
         r.front_value = shadow_elem[0];
         r.back_value  = shadow_elem[shadow_len-1];
      end
      if (shadow_cur < shadow_len) r.next_value = shadow_elem[shadow_cur];
      if (shadow_cur > 0) r.prev_value = shadow_elem[shadow_cur-1];
      return r;
   endfunction

   task automatic queue_cmd(logic [3:0] op, logic [31:0] val, bit drain = 0, bit steady = 0);
      cmd_slot_type s;
      s.cmd.op = op;
      s.cmd.operand = val;
      s.drain = drain;
      s.steady = steady;
      cmd_queue.push_back(s);
      planned_rsp.push_back(apply_list_cmd(s.cmd));
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return 32'h8000_0000;
         2:       return 32'h7FFF_FFFF;
         3:       return -32'sd100;
         default: return value_pool[$urandom_range(0, 7)];
      endcase
   endfunction

   // Stimulus: directed corners, one full fill, then random commands.
   initial begin
      logic [3:0] op;
      int         roll;
      foreach (value_pool[i]) value_pool[i] = $urandom();
      value_pool[0] = -32'sd100;
      value_pool[1] = 32'd0;

      // empty-list corners: moves, sets and erases past an end, a failed search, dedupe
      queue_cmd(OP_QUERY, 0);
      queue_cmd(OP_NEXT, 0);
      queue_cmd(OP_PREV, 0);
      queue_cmd(OP_SET_AFTER, 5);
      queue_cmd(OP_SET_BEFORE, 5);
      queue_cmd(OP_ERASE_AFTER, 0);
      queue_cmd(OP_ERASE_BEFORE, 0);
      queue_cmd(OP_FIND_NEXT, 1);
      queue_cmd(OP_DEDUPE, 0);
      // field extremes and the search for -100
      queue_cmd(OP_INS_BEFORE, 32'h8000_0000);
      queue_cmd(OP_INS_AFTER, 32'h7FFF_FFFF);
      queue_cmd(OP_INS_BEFORE, -32'sd100);
      queue_cmd(OP_INS_AFTER, 32'hFFFF_FFFF);
      queue_cmd(OP_INS_BEFORE, 32'h8000_0000);
      queue_cmd(OP_FIND_PREV, -32'sd100);
      queue_cmd(OP_FIND_NEXT, 32'h7FFF_FFFF);
      queue_cmd(OP_FIND_PREV, 12345);
      queue_cmd(OP_SET_AFTER, 32'h0000_0000);
      queue_cmd(OP_SET_BEFORE, 32'h5555_AAAA);
      queue_cmd(OP_BACK, 0);
      queue_cmd(OP_PREV, 0);
      queue_cmd(OP_DEDUPE, 0);
      queue_cmd(OP_FRONT, 0, 1);
      queue_cmd(OP_SPARE, 32'hFFFF_FFFF);
      queue_cmd(OP_CLEAR, 0);

      // fill the store to capacity, check the full case and long searches;
      // part of the fill runs with no idling at all
      for (int i = 0; i < LIST_CAP; i++)
         queue_cmd($urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE, $urandom(), 0,
                   i >= 256 && i < 640);
      queue_cmd(OP_INS_AFTER, 1);
      queue_cmd(OP_INS_BEFORE, 1);
      queue_cmd(OP_FRONT, 0);
      queue_cmd(OP_FIND_NEXT, -32'sd100);
      queue_cmd(OP_FIND_PREV, -32'sd100);
      queue_cmd(OP_CLEAR, 0, 1);

      // random commands over a short list
      for (int n = 0; n < 50; n++) begin
         roll = $urandom_range(0, 99);
         if (shadow_len > 40 && roll < 30)
            op = $urandom_range(0, 1) ? OP_ERASE_AFTER : OP_ERASE_BEFORE;
         else if (roll < 30)
            op = $urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE;
         else if (roll < 32)
            op = OP_CLEAR;
         else
            op = 4'($urandom_range(0, 15));
         if (op == OP_DEDUPE && shadow_len > 48) op = OP_ERASE_BEFORE;
         queue_cmd(op, pick_value(), n == 25, 1'b0);
      end
      gen_done = 1'b1;
   end

   // Driver: present commands from the queue; hold each until accepted.
   always @(posedge clock) begin
      cmd_slot_type s;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            awaited_rsp.push_back(planned_rsp.pop_front());
            void'(cmd_queue.pop_front());
         end
         if (start && busy) begin
            start <= 1'b1;  // hold the offered item
         end else if (cmd_queue.size() > 0) begin
            s = cmd_queue[0];
            if (s.drain && (awaited_rsp.size() > 0 || busy || (start && !busy)))
               start <= 1'b0;
            else if (!s.steady && $urandom_range(0, 99) < 27)
               start <= 1'b0;
            else begin
               start <= 1'b1;
               req_item <= s.cmd;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (awaited_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORT)
               $display("unexpected result %p", rsp_item);
         end else begin
            exp_rsp = awaited_rsp.pop_front();
            if (rsp_item !== exp_rsp) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORT)
                  $display("mismatch: expected %p actual %p", exp_rsp, rsp_item);
            end
         end
      end
   end

   // Watchdog: count cycles in which neither a command nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (gen_done);
      while (cmd_queue.size() > 0 || awaited_rsp.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
